FILE: rtl/core/sm3_hash_engine_assert.svh
// Assertion macros for the SM3 hash engine.
// Used by sm3_hash_engine.sv; no other dependencies.
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH

`define SM3_ASSERT_IMP(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |-> (rhs)) \
      else $error("assertion failed");

`define SM3_ASSERT_NEXT(label, clk, rst, lhs, rhs) \
   label: assert property (@(posedge clk) disable iff (rst) (lhs) |=> (rhs)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/sm3_pkg.sv
// Shared types and constants for the SM3 hash engine.
// No dependencies.
package sm3_pkg;

   typedef struct packed {
      logic [31:0] message_word;
      logic [2:0]  bytes_valid;
      logic        last_word;
   } req_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  digest_index;
      logic        digest_last;
   } rsp_type;

   localparam logic [2:0] CSR_IV_MODE     = 3'd0;
   localparam logic [2:0] CSR_IV_PAIR_01  = 3'd1;
   localparam logic [2:0] CSR_IV_PAIR_23  = 3'd2;
   localparam logic [2:0] CSR_IV_PAIR_45  = 3'd3;
   localparam logic [2:0] CSR_IV_PAIR_67  = 3'd4;
   localparam logic [2:0] CSR_LENGTH_BIAS = 3'd5;

   localparam logic [31:0] T_LOW  = 32'h79CC4519;
   localparam logic [31:0] T_HIGH = 32'h7A879D8A;
   localparam logic [31:0] PAD    = 32'h80000000;

   localparam logic [255:0] STD_IV = {
      32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
      32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

   // round controls shared by the sequencer and the round unit
   typedef struct packed {
      logic       start;
      logic       step;
      logic [5:0] round;
   } rnd_ctl_type;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] d;
      d = {x, x} << n;
      return d[63:32];
   endfunction

   function automatic logic [31:0] p0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] p1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

FILE: rtl/core/sm3_round.sv
// SM3 compression round unit: one round per cycle, with message expansion.
// Depends on sm3_pkg.
module sm3_round (
   input  logic                 clock,
   input  sm3_pkg::rnd_ctl_type ctl,
   input  logic [511:0]         block_in,
   input  logic [255:0]         cv_in,
   output logic [255:0]         state_out
);
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] r_ff [8];
   logic [31:0] r_in [8];
   logic [31:0] nw, wj, wpj, tj, a12, ss1, ss2, ff, gg, tt1, tt2;
   logic [5:0]  j;
   logic [3:0]  k;

   always_comb begin
      j   = ctl.round;
      k   = j[3:0] + 4'd4;
      nw  = sm3_pkg::p1(w_ff[k] ^ w_ff[k + 4'd7] ^ sm3_pkg::rotl(w_ff[k + 4'd13], 5'd15))
            ^ sm3_pkg::rotl(w_ff[k + 4'd3], 5'd7) ^ w_ff[k + 4'd10];
      for (int i = 0; i < 16; i++) w_in[i] = w_ff[i];
      if (j >= 6'd12) w_in[k] = nw;
      wj  = w_in[j[3:0]];
      wpj = wj ^ w_in[k];
      tj  = (j < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12 = sm3_pkg::rotl(r_ff[0], 5'd12);
      ss1 = sm3_pkg::rotl(a12 + r_ff[4] + sm3_pkg::rotl(tj, j[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (j < 6'd16) begin
         ff = r_ff[0] ^ r_ff[1] ^ r_ff[2];
         gg = r_ff[4] ^ r_ff[5] ^ r_ff[6];
      end else begin
         ff = (r_ff[0] & r_ff[1]) | (r_ff[0] & r_ff[2]) | (r_ff[1] & r_ff[2]);
         gg = (r_ff[4] & r_ff[5]) | (~r_ff[4] & r_ff[6]);
      end
      tt1 = ff + r_ff[3] + ss2 + wpj;
      tt2 = gg + r_ff[7] + ss1 + wj;
      r_in[0] = tt1;
      r_in[1] = r_ff[0];
      r_in[2] = sm3_pkg::rotl(r_ff[1], 5'd9);
      r_in[3] = r_ff[2];
      r_in[4] = sm3_pkg::p0(tt2);
      r_in[5] = r_ff[4];
      r_in[6] = sm3_pkg::rotl(r_ff[5], 5'd19);
      r_in[7] = r_ff[6];
      for (int i = 0; i < 8; i++) state_out[255 - 32*i -: 32] = r_ff[i];
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= block_in[511 - 32*i -: 32];
         for (int i = 0; i < 8; i++) r_ff[i] <= cv_in[255 - 32*i -: 32];
      end else if (ctl.step) begin
         w_ff <= w_in;
         r_ff <= r_in;
      end
   end
endmodule

FILE: rtl/core/sm3_hash_engine.sv
// SM3 hash engine top level: word intake, padding sequencer, digest output.
// Depends on sm3_pkg, sm3_round and sm3_hash_engine_assert.svh.
//
// Usage: message words arrive on req_ (valid/stall), big-endian, the last one
// flagged with req_last_word and carrying 1..4 valid bytes. Each word is one
// transfer. Every 16th word starts a 64-round compression at one round per
// cycle on the single shared round unit, during which req_stall is high and no
// word is taken. On the last word the engine pads at one word per cycle and
// runs the remaining one or two compressions; digest word 0 is offered once
// the final compression has folded into the chaining value. The eight digest
// words then leave on rsp_, one transfer each, index 0 first.
// A stalled rsp_ holds the current word; no new message word is taken until
// all eight are gone. csr_ writes set IV mode, configured IV and length bias;
// the IV is latched at the first word of each message.
// Synchronous active-high reset clears the sequencer and the configuration
// registers and returns the chaining value to the standard IV.
module sm3_hash_engine (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  sm3_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output sm3_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic [2:0]       csr_index,
   input  logic [63:0]      csr_wdata
);
   typedef enum logic [5:0] {
      ST_IDLE = 6'b000001, ST_LOAD = 6'b000010, ST_RUN  = 6'b000100,
      ST_FOLD = 6'b001000, ST_PAD  = 6'b010000, ST_OUT  = 6'b100000
   } state_type;

   state_type   st_ff, st_in;
   logic        iv_mode_ff;
   logic [255:0] iv_ff;
   logic [31:0] bias_ff;
   logic [255:0] cv_ff, cv_in;
   logic [511:0] blk_ff, blk_in;
   logic [3:0]  cnt_ff, cnt_in;
   logic [63:0] bits_ff, bits_in;
   logic        open_ff, open_in;
   logic        fin_ff, fin_in;
   logic        lenw_ff, lenw_in;
   logic [5:0]  rnd_ff, rnd_in;
   logic [2:0]  oidx_ff, oidx_in;
   logic [255:0] rstate;
   sm3_pkg::rnd_ctl_type ctl;
   logic        req_fire, rsp_fire;
   logic [63:0] len;
   logic [2:0]  nb;
   logic [31:0] pw;

   assign req_stall = (st_ff != ST_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign rsp_valid = (st_ff == ST_OUT);
   assign rsp_fire  = rsp_valid && !rsp_stall;
   assign rsp_data.digest_word  = cv_ff[255 - 32*oidx_ff -: 32];
   assign rsp_data.digest_index = oidx_ff;
   assign rsp_data.digest_last  = (oidx_ff == 3'd7);
   assign len = bits_ff + {32'd0, bias_ff};

   assign ctl.start = (st_ff == ST_LOAD);
   assign ctl.step  = (st_ff == ST_RUN);
   assign ctl.round = rnd_ff;

   sm3_round u_round (
      .clock(clock), .ctl(ctl), .block_in(blk_ff), .cv_in(cv_ff), .state_out(rstate));

   always_ff @(posedge clock) begin
      if (reset) begin
         iv_mode_ff <= 1'b0;
         iv_ff      <= '0;
         bias_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            sm3_pkg::CSR_IV_MODE:     iv_mode_ff <= csr_wdata[0];
            sm3_pkg::CSR_IV_PAIR_01:  iv_ff[255:192] <= csr_wdata;
            sm3_pkg::CSR_IV_PAIR_23:  iv_ff[191:128] <= csr_wdata;
            sm3_pkg::CSR_IV_PAIR_45:  iv_ff[127:64]  <= csr_wdata;
            sm3_pkg::CSR_IV_PAIR_67:  iv_ff[63:0]    <= csr_wdata;
            sm3_pkg::CSR_LENGTH_BIAS: bias_ff <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      st_in = st_ff; cv_in = cv_ff; blk_in = blk_ff; cnt_in = cnt_ff;
      bits_in = bits_ff; open_in = open_ff; fin_in = fin_ff; lenw_in = lenw_ff;
      rnd_in = rnd_ff; oidx_in = oidx_ff;
      nb = 3'd4; pw = '0;
      case (st_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (!open_ff) begin
                  cv_in   = iv_mode_ff ? iv_ff : sm3_pkg::STD_IV;
                  bits_in = '0;
                  cnt_in  = '0;
               end
               open_in = 1'b1;
               if (req_data.last_word) begin
                  nb = (req_data.bytes_valid > 3'd4) ? 3'd4 : req_data.bytes_valid;
                  fin_in = 1'b1;
               end
               bits_in = bits_in + {58'd0, nb, 3'd0};
               if (nb == 3'd4) pw = req_data.message_word;
               else begin
                  pw = (req_data.message_word & ~(32'hffffffff >> {nb, 3'd0}))
                       | (sm3_pkg::PAD >> {nb, 3'd0});
               end
               blk_in[511 - 32*cnt_in -: 32] = pw;
               // a full last word still needs its pad word
               lenw_in = req_data.last_word && (nb == 3'd4);
               cnt_in = cnt_in + 4'd1;
               // pad marker in word 13: the length still fits this block
               if (nb != 3'd4 && cnt_in == 4'd14) fin_in = 1'b0;
               if (cnt_in == 4'd0) st_in = ST_LOAD;
               else if (req_data.last_word) st_in = ST_PAD;
            end
         end
         ST_PAD: begin
            // one word per cycle: pad marker, zero fill, then length
            if (lenw_ff) begin
               pw = sm3_pkg::PAD;
               lenw_in = 1'b0;
            end else if (cnt_ff == 4'd14 && !fin_ff) pw = len[63:32];
            else if (cnt_ff == 4'd15 && !fin_ff) pw = len[31:0];
            else pw = '0;
            blk_in[511 - 32*cnt_ff -: 32] = pw;
            if (cnt_ff == 4'd13) fin_in = 1'b0;
            if (cnt_ff == 4'd15 && !lenw_ff && !fin_ff) fin_in = 1'b1;
            cnt_in = cnt_ff + 4'd1;
            if (cnt_in == 4'd0) st_in = ST_LOAD;
         end
         ST_LOAD: begin
            rnd_in = '0;
            st_in  = ST_RUN;
         end
         ST_RUN: begin
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) st_in = ST_FOLD;
         end
         ST_FOLD: begin
            cv_in = cv_ff ^ rstate;
            if (!fin_ff) st_in = (open_ff && cnt_ff == 4'd0 && bits_ff != '0 && lenw_ff)
                                 ? ST_PAD : ST_IDLE;
            else st_in = ST_PAD;
            if (!open_ff) begin
               st_in = ST_OUT;
               oidx_in = '0;
            end
         end
         ST_OUT: begin
            if (rsp_fire) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) st_in = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase
      // the length word just written closes the message
      if (st_ff == ST_PAD && cnt_ff == 4'd15 && !fin_ff && !lenw_ff) open_in = 1'b0;
      if (st_ff == ST_PAD && cnt_ff == 4'd15 && !fin_ff && !lenw_ff) fin_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= ST_IDLE;
         cv_ff   <= sm3_pkg::STD_IV;
         cnt_ff  <= '0;
         bits_ff <= '0;
         open_ff <= 1'b0;
         fin_ff  <= 1'b0;
         lenw_ff <= 1'b0;
         rnd_ff  <= '0;
         oidx_ff <= '0;
      end else begin
         st_ff   <= st_in;
         cv_ff   <= cv_in;
         cnt_ff  <= cnt_in;
         bits_ff <= bits_in;
         open_ff <= open_in;
         fin_ff  <= fin_in;
         lenw_ff <= lenw_in;
         rnd_ff  <= rnd_in;
         oidx_ff <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      blk_ff <= blk_in;
   end

`include "sm3_hash_engine_assert.svh"

   `SM3_ASSERT_IMP(a_no_req_busy, clock, reset, st_ff != ST_IDLE, !req_fire)
   `SM3_ASSERT_NEXT(a_load_runs, clock, reset, st_ff == ST_LOAD, st_ff == ST_RUN && rnd_ff == 6'd0)
   `SM3_ASSERT_NEXT(a_out_done, clock, reset, rsp_fire && rsp_data.digest_last, st_ff == ST_IDLE)
endmodule
